// File: hw/rtl/fulf_pkg.sv
`timescale 1ns / 1ps

package fulf_pkg;

  localparam longint unsigned MAX_LEN = 65536;
  localparam int unsigned POS_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = POS_W + 1;
  localparam int unsigned ALPHABET = 26;
  localparam int unsigned IDX_W = $clog2(ALPHABET);
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = Q_PTR_W + 1;

  localparam logic [7:0] ASCII_A = 8'h61;
  localparam logic [7:0] ASCII_UNDERSCORE = 8'h5F;

  typedef struct packed {
    logic [4:0] letter;
    logic       last_letter;
  } in_t;

  typedef struct packed {
    logic [7:0] result_char;
    logic       found;
    logic       too_long;
  } out_t;

  // one classified letter as it travels from front to back
  typedef struct packed {
    logic             is_letter;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             too_long;
  } q_entry_t;

  // queue status seen by the back end
  typedef struct packed {
    logic     valid;
    q_entry_t head;
  } q_head_t;

endpackage

// File: hw/rtl/fulf_front.sv
`timescale 1ns / 1ps

module fulf_front import fulf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_t      in_data,
  output q_entry_t entry
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             is_letter;
  logic             sat;

  assign is_letter = (32'(in_data.letter) < ALPHABET);
  assign sat = (cnt_r >= CNT_W'(MAX_LEN));

  always_comb begin
    entry.is_letter = is_letter;
    entry.idx = IDX_W'(in_data.letter);
    entry.pos = sat ? POS_W'(MAX_LEN - 1) : cnt_r[POS_W-1:0];
    entry.last = in_data.last_letter;
    entry.too_long = ovf_r | (is_letter & sat);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (in_data.last_letter) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (is_letter) begin
        if (sat) begin
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// File: hw/rtl/fulf_queue.sv
`timescale 1ns / 1ps

module fulf_queue import fulf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_head_t  head,
  output logic     full
);

  q_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign do_push = push & ~full;
  assign do_pop = pop & (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// File: hw/rtl/fulf_back.sv
`timescale 1ns / 1ps

module fulf_back import fulf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_head_t head,
  output logic    pop,
  output logic    out_strobe,
  output out_t    out_data
);

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [ALPHABET-1:0]   seen_r, seen_nxt;
  logic [ALPHABET-1:0]   rep_r, rep_nxt;
  logic [POS_W-1:0]      pos_mem_r [ALPHABET];
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  have_r, have_nxt;
  logic [IDX_W-1:0]      best_r, best_nxt;
  logic [POS_W-1:0]      best_pos_r, best_pos_nxt;
  logic                  tl_r, tl_nxt;
  logic                  strobe_r, strobe_nxt;
  out_t                  out_r, out_nxt;
  logic                  cand, better, scan_end;
  logic                  fin_have;
  logic [IDX_W-1:0]      fin_best;
  logic                  wr_pos;

  assign pop = (state_r == S_RUN) & head.valid;
  assign out_strobe = strobe_r;
  assign out_data = out_r;

  assign cand = seen_r[idx_r] & ~rep_r[idx_r];
  assign better = cand & (~have_r | (pos_mem_r[idx_r] < best_pos_r));
  assign scan_end = (idx_r == IDX_W'(ALPHABET - 1));
  assign fin_have = have_r | better;
  assign fin_best = better ? idx_r : best_r;
  assign wr_pos = pop & head.head.is_letter & ~seen_r[head.head.idx];

  always_comb begin
    state_nxt = state_r;
    seen_nxt = seen_r;
    rep_nxt = rep_r;
    idx_nxt = idx_r;
    have_nxt = have_r;
    best_nxt = best_r;
    best_pos_nxt = best_pos_r;
    tl_nxt = tl_r;
    strobe_nxt = 1'b0;
    out_nxt = out_r;
    unique case (state_r)
      S_RUN: begin
        if (pop) begin
          if (head.head.is_letter) begin
            if (seen_r[head.head.idx]) begin
              rep_nxt[head.head.idx] = 1'b1;
            end else begin
              seen_nxt[head.head.idx] = 1'b1;
            end
          end
          if (head.head.last) begin
            state_nxt = S_SCAN;
            idx_nxt = '0;
            have_nxt = 1'b0;
            tl_nxt = head.head.too_long;
          end
        end
      end
      S_SCAN: begin
        if (better) begin
          have_nxt = 1'b1;
          best_nxt = idx_r;
          best_pos_nxt = pos_mem_r[idx_r];
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (scan_end) begin
          state_nxt = S_RUN;
          strobe_nxt = 1'b1;
          out_nxt.result_char = fin_have ? ASCII_A + 8'(fin_best) : ASCII_UNDERSCORE;
          out_nxt.found = fin_have;
          out_nxt.too_long = tl_r;
          seen_nxt = '0;
          rep_nxt = '0;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      seen_r <= '0;
      rep_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r <= seen_nxt;
      rep_r <= rep_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    have_r <= have_nxt;
    best_r <= best_nxt;
    best_pos_r <= best_pos_nxt;
    tl_r <= tl_nxt;
    out_r <= out_nxt;
    if (wr_pos) begin
      pos_mem_r[head.head.idx] <= head.head.pos;
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !pop)
    else $error("queue popped during scan");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held longer than one cycle");

  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (seen_r == '0) && (rep_r == '0))
    else $error("letter flags not cleared after string");

  a_none_char: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !out_r.found) |-> (out_r.result_char == ASCII_UNDERSCORE))
    else $error("no unique letter but result is not underscore");
`endif

endmodule

// File: hw/rtl/first_unique_letter_finder.sv
`timescale 1ns / 1ps

// Finds the first non-repeating letter of a string fed one letter code (0 = 'a'
// .. 25 = 'z') per beat, the final letter flagged by last_letter. A beat is
// taken when start is high and busy is low; codes 26..31 are ignored but a
// flagged one still ends the string. Letters are taken one per cycle, while
// busy is low, into a four-entry queue; the table update drains that queue at
// one letter per cycle outside the scan. Once the final letter leaves the
// queue, the table logic walks all 26 letters, one per cycle, and then
// raises the one-cycle out_strobe. busy rises only while that queue is full.
// The receiver cannot stall: out_data is valid only in the cycle of
// out_strobe. Positions saturate at MAX_LEN - 1, and too_long flags a string
// longer than MAX_LEN letters.
module first_unique_letter_finder import fulf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_strobe,
  output out_t out_data
);

  logic     accept;
  logic     pop;
  logic     full;
  q_entry_t entry;
  q_head_t  head;

  assign busy = full;
  assign accept = start & ~busy;

  fulf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .entry   (entry)
  );

  fulf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .full       (full)
  );

  fulf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// File: verif/first_unique_letter_check.sv
`timescale 1ns / 1ps

module first_unique_letter_check import fulf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_strobe,
  input  out_t out_data,
  output int   fail_count,
  output int   answers_open,
  output int   answers_checked
);

  logic             seen [ALPHABET];
  logic             repeated [ALPHABET];
  logic [POS_W-1:0] first_pos [ALPHABET];
  logic [CNT_W-1:0] letter_count;
  logic             overflowed;
  out_t             expected_answers [$];

  task automatic clear_tables();
    for (int i = 0; i < ALPHABET; i++) begin
      seen[i] = 1'b0;
      repeated[i] = 1'b0;
      first_pos[i] = '0;
    end
    letter_count = '0;
    overflowed = 1'b0;
  endtask

  task automatic take_letter(input in_t beat);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] best_pos;
    logic [IDX_W-1:0] best;
    logic             have;
    out_t             answer;
    if (beat.letter < ALPHABET) begin
      if (letter_count >= MAX_LEN) begin
        overflowed = 1'b1;
        pos = POS_W'(MAX_LEN - 1);
      end else begin
        pos = letter_count[POS_W-1:0];
        letter_count = letter_count + 1'b1;
      end
      if (!seen[beat.letter]) begin
        seen[beat.letter] = 1'b1;
        first_pos[beat.letter] = pos;
      end else begin
        repeated[beat.letter] = 1'b1;
      end
    end
    if (beat.last_letter) begin
      have = 1'b0;
      best = '0;
      best_pos = '0;
      // strict compare: on a tie of saturated positions the lower code wins
      for (int i = 0; i < ALPHABET; i++) begin
        if (seen[i] && !repeated[i] && (!have || first_pos[i] < best_pos)) begin
          have = 1'b1;
          best = IDX_W'(i);
          best_pos = first_pos[i];
        end
      end
      answer.result_char = have ? ASCII_A + 8'(best) : ASCII_UNDERSCORE;
      answer.found = have;
      answer.too_long = overflowed;
      expected_answers.push_back(answer);
      clear_tables();
    end
  endtask

  task automatic check_answer(input out_t got);
    out_t want;
    if (expected_answers.size() == 0) begin
      $error("unexpected result: result_char %0d found %0d too_long %0d",
             got.result_char, got.found, got.too_long);
      fail_count++;
      return;
    end
    want = expected_answers.pop_front();
    answers_checked++;
    if (got.result_char !== want.result_char) begin
      $error("result_char: expected %0d, got %0d", want.result_char, got.result_char);
      fail_count++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      fail_count++;
    end
    if (got.too_long !== want.too_long) begin
      $error("too_long: expected %0d, got %0d", want.too_long, got.too_long);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tables();
      expected_answers.delete();
    end else begin
      // a result never belongs to a string ending on the same edge
      if (out_strobe === 1'b1) check_answer(out_data);
      if (start && !busy) take_letter(in_data);
    end
    answers_open = expected_answers.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fulf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_strobe;
  out_t out_data;

  int fail_count;
  int answers_open;
  int answers_checked;
  int letters_sent = 0;
  int strings_sent = 0;
  int burst_left = 0;
  int random_items = 0;
  int len;
  int base;
  int span;
  logic [4:0] code;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  first_unique_letter_finder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  first_unique_letter_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_strobe     (out_strobe),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .answers_open   (answers_open),
    .answers_checked(answers_checked)
  );

  task automatic send_letter(input logic [4:0] letter, input logic last);
    @(negedge clk);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    in_data <= '{letter: letter, last_letter: last};
    do @(posedge clk); while (busy);
    if (letter < ALPHABET) letters_sent++;
    if (last) strings_sent++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // empty strings, single letters at both ends of the alphabet
    send_letter(5'd31, 1'b1);
    send_letter(5'd26, 1'b1);
    send_letter(5'd0, 1'b1);
    send_letter(5'd25, 1'b1);
    // everything repeated
    send_letter(5'd0, 1'b0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd1, 1'b0);
    send_letter(5'd1, 1'b1);
    // ignored code in the middle
    send_letter(5'd0, 1'b0);
    send_letter(5'd30, 1'b0);
    send_letter(5'd1, 1'b0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd2, 1'b1);
    send_letter(5'd25, 1'b0);
    send_letter(5'd24, 1'b0);
    send_letter(5'd25, 1'b1);
    // ignored code carries the end of string
    send_letter(5'd3, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd3, 1'b0);
    send_letter(5'd29, 1'b1);

    while (random_items < 1930) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      base = $urandom_range(0, 25);
      span = $urandom_range(1, 26);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) code = 5'($urandom_range(26, 31));
        else code = 5'((base + $urandom_range(0, span - 1)) % ALPHABET);
        send_letter(code, k == len - 1);
        random_items++;
      end
    end

    @(negedge clk) start <= 1'b0;
    while (answers_open != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d strings, %0d letters with ignored codes mixed in; %0d answers compared",
             strings_sent, letters_sent, answers_checked);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb_top: errors");
    $finish;
  end

endmodule
